FILE: hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg - shared types and constants for the websocket frame deframer
// Result kinds, header field constants and the result record that the
// parser hands to the output queue.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // width of the payload length limit register
    localparam int MAX_LEN_W = 63;

    // header constants
    localparam logic [7:0] RSV_MASK = 8'h70;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_RSV_ERR = 2'd2,
        KIND_LEN_ERR = 2'd3
    } kind_t;

    // one result beat
    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       fin_flag;
        logic [3:0] frame_opcode;
        logic       was_masked;
        logic       last_of_frame;
    } result_t;

endpackage

FILE: hw/rtl/wsd_if.sv
// ----------------------------------------------------------------------------
// wsd_if - stream channels of the websocket frame deframer
// Input byte channel and output result channel, valid/ready handshake.
// ----------------------------------------------------------------------------

// raw byte stream channel
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

// result channel
interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       fin_flag;
    logic [3:0] frame_opcode;
    logic       was_masked;
    logic       last_of_frame;

    modport source (
        output valid, output kind, output payload_byte, output fin_flag,
        output frame_opcode, output was_masked, output last_of_frame,
        input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input fin_flag,
        input frame_opcode, input was_masked, input last_of_frame,
        output ready
    );
endinterface

FILE: hw/rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser - frame header parser and payload unmasker
// Advances the frame state by one byte per accepted beat and produces at
// most one result record for that byte.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [MAX_LEN_W-1:0] max_len,
    input  logic                 step,
    input  logic [7:0]           stream_byte,
    output logic                 res_valid,
    output result_t              res
);

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  ext_count_reg, ext_count_next;
    logic [1:0]  key_count_reg, key_count_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [63:0] length_left_reg, length_left_next;
    logic [31:0] key_bytes_reg, key_bytes_next;
    logic [1:0]  key_index_reg, key_index_next;

    logic        len_known;
    logic        start_payload;
    kind_t       emit_kind;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic [7:0]  key_byte;

    // current mask key byte for the payload
    always_comb
    begin
        case (key_index_reg)
            2'd0:    key_byte = key_bytes_reg[7:0];
            2'd1:    key_byte = key_bytes_reg[15:8];
            2'd2:    key_byte = key_bytes_reg[23:16];
            default: key_byte = key_bytes_reg[31:24];
        endcase
    end

    // next state and result for one byte
    always_comb
    begin
        phase_next       = phase_reg;
        ext_count_next   = ext_count_reg;
        key_count_next   = key_count_reg;
        fin_next         = fin_reg;
        opcode_next      = opcode_reg;
        masked_next      = masked_reg;
        length_left_next = length_left_reg;
        key_bytes_next   = key_bytes_reg;
        key_index_next   = key_index_reg;
        len_known        = 1'b0;
        start_payload    = 1'b0;
        res_valid        = 1'b0;
        emit_kind        = KIND_DATA;
        emit_byte        = 8'd0;
        emit_last        = 1'b0;

        case (phase_reg)
            PH_HDR1:
            begin
                masked_next = stream_byte[7];
                if (stream_byte[6:0] == LEN_EXT16)
                begin
                    ext_count_next   = 3'd1;
                    length_left_next = 64'd0;
                    phase_next       = PH_EXT;
                end
                else if (stream_byte[6:0] == LEN_EXT64)
                begin
                    ext_count_next   = 3'd7;
                    length_left_next = 64'd0;
                    phase_next       = PH_EXT;
                end
                else
                begin
                    length_left_next = {57'd0, stream_byte[6:0]};
                    len_known        = 1'b1;
                end
            end
            PH_EXT:
            begin
                // big-endian length, shift in one byte
                length_left_next = {length_left_reg[55:0], stream_byte};
                if (ext_count_reg == 3'd0)
                    len_known = 1'b1;
                else
                    ext_count_next = ext_count_reg - 3'd1;
            end
            PH_KEY:
            begin
                // key slots were cleared, so writing the slot equals or-ing it in
                key_bytes_next[{key_count_reg, 3'b000} +: 8] = stream_byte;
                if (key_count_reg == 2'd3)
                begin
                    key_count_next = 2'd0;
                    start_payload  = 1'b1;
                end
                else
                begin
                    key_count_next = key_count_reg + 2'd1;
                end
            end
            PH_DATA:
            begin
                key_index_next   = key_index_reg + 2'd1;
                length_left_next = length_left_reg - 64'd1;
                res_valid        = 1'b1;
                emit_kind        = KIND_DATA;
                emit_byte        = masked_reg ? (stream_byte ^ key_byte) : stream_byte;
                emit_last        = (length_left_reg == 64'd1);
                if (length_left_reg == 64'd1)
                    phase_next = PH_HDR0;
            end
            default:
            begin
                // first header byte
                fin_next    = stream_byte[7];
                opcode_next = stream_byte[3:0];
                masked_next = 1'b0;
                if ((stream_byte & RSV_MASK) != 8'd0)
                begin
                    phase_next = PH_HDR0;
                    res_valid  = 1'b1;
                    emit_kind  = KIND_RSV_ERR;
                    emit_last  = 1'b1;
                end
                else
                begin
                    phase_next = PH_HDR1;
                end
            end
        endcase

        // full length known: limit check, then key or payload
        if (len_known)
        begin
            if (length_left_next > {1'b0, max_len})
            begin
                phase_next       = PH_HDR0;
                length_left_next = 64'd0;
                res_valid        = 1'b1;
                emit_kind        = KIND_LEN_ERR;
                emit_last        = 1'b1;
            end
            else if (masked_next)
            begin
                key_count_next = 2'd0;
                key_bytes_next = 32'd0;
                phase_next     = PH_KEY;
            end
            else
            begin
                start_payload = 1'b1;
            end
        end

        // payload start, empty frame gives one result
        if (start_payload)
        begin
            key_index_next = 2'd0;
            if (length_left_next == 64'd0)
            begin
                phase_next = PH_HDR0;
                res_valid  = 1'b1;
                emit_kind  = KIND_EMPTY;
                emit_last  = 1'b1;
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end

        res.kind          = emit_kind;
        res.payload_byte  = emit_byte;
        res.fin_flag      = fin_next;
        res.frame_opcode  = opcode_next;
        res.was_masked    = masked_next;
        res.last_of_frame = emit_last;
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            ext_count_reg   <= 3'd0;
            key_count_reg   <= 2'd0;
            fin_reg         <= 1'b0;
            opcode_reg      <= 4'd0;
            masked_reg      <= 1'b0;
            length_left_reg <= 64'd0;
            key_bytes_reg   <= 32'd0;
            key_index_reg   <= 2'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            ext_count_reg   <= ext_count_next;
            key_count_reg   <= key_count_next;
            fin_reg         <= fin_next;
            opcode_reg      <= opcode_next;
            masked_reg      <= masked_next;
            length_left_reg <= length_left_next;
            key_bytes_reg   <= key_bytes_next;
            key_index_reg   <= key_index_next;
        end
    end

endmodule

FILE: hw/rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer - streaming websocket frame parser
// Parses frame headers from a byte stream and delivers unmasked payload
// bytes, empty-frame markers and error markers as result beats.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    stream_byte[7:0]
//  out_ch   out  valid/ready    kind, payload_byte, fin_flag, frame_opcode,
//                               was_masked, last_of_frame
//  cfg      in   cfg_wr_en      cfg_wr_data[62:0] (max payload length)
//
// one byte per cycle while in_ch.ready is high; each result is registered into
// the output queue before it shows on out_ch; a two-entry output queue lets input
// continue while a result is pending; in_ch.ready drops only when both entries are held
// header bytes and mask key bytes produce no result but error and empty-frame markers
// rst_n clears the parser to await a first header byte, limit to 2^63-1
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [MAX_LEN_W-1:0] cfg_wr_data,
    wsd_in_if.sink               in_ch,
    wsd_out_if.source            out_ch
);

    logic [MAX_LEN_W-1:0] max_len_reg;
    logic                 step;
    logic                 res_valid;
    result_t              res;
    logic                 push, pop;

    result_t              head_reg, head_next;
    result_t              tail_reg, tail_next;
    logic                 head_vld_reg, head_vld_next;
    logic                 tail_vld_reg, tail_vld_next;
    logic                 head_vld_after;

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= {MAX_LEN_W{1'b1}};
        else if (cfg_wr_en)
            max_len_reg <= cfg_wr_data;
    end

    // input beat handshake
    assign in_ch.ready = !tail_vld_reg;
    assign step        = in_ch.valid && in_ch.ready;

    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_len     (max_len_reg),
        .step        (step),
        .stream_byte (in_ch.stream_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    // two-entry output queue
    assign push = step && res_valid;
    assign pop  = head_vld_reg && out_ch.ready;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        head_vld_next = head_vld_reg;
        tail_vld_next = tail_vld_reg;
        if (pop)
        begin
            head_next     = tail_reg;
            head_vld_next = tail_vld_reg;
            tail_vld_next = 1'b0;
        end
        head_vld_after = head_vld_next;
        if (push)
        begin
            if (head_vld_after)
            begin
                tail_next     = res;
                tail_vld_next = 1'b1;
            end
            else
            begin
                head_next     = res;
                head_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            tail_vld_reg <= 1'b0;
        end
        else
        begin
            head_vld_reg <= head_vld_next;
            tail_vld_reg <= tail_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    // result beat outputs
    assign out_ch.valid         = head_vld_reg;
    assign out_ch.kind          = head_reg.kind;
    assign out_ch.payload_byte  = head_reg.payload_byte;
    assign out_ch.fin_flag      = head_reg.fin_flag;
    assign out_ch.frame_opcode  = head_reg.frame_opcode;
    assign out_ch.was_masked    = head_reg.was_masked;
    assign out_ch.last_of_frame = head_reg.last_of_frame;

`ifndef SYNTHESIS
    // tail entry is never held without a head entry
    a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        tail_vld_reg |-> head_vld_reg)
        else $error("output queue tail valid without head");

    // a drained head is refilled from the tail
    a_tail_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && tail_vld_reg) |=> (head_vld_reg && head_reg == $past(tail_reg)))
        else $error("tail entry not moved to head");

    // a held head that is not taken keeps its value
    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (head_vld_reg && !out_ch.ready) |=> (head_vld_reg && $stable(head_reg)))
        else $error("pending result changed");

    // non-data results always close a frame
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res.kind != KIND_DATA) |-> res.last_of_frame)
        else $error("marker result without last flag");
`endif

endmodule

FILE: sim/deframe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframe_checker - result checker for the websocket frame deframer
// Follows every accepted stream byte and limit write, works out the result
// beat each byte should give, and compares the result channel in order.
// ----------------------------------------------------------------------------
module deframe_checker
    import wsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [MAX_LEN_W-1:0] cfg_wr_data,
    wsd_in_if                    in_ch,
    wsd_out_if                   out_ch,
    output int                   mismatch_count,
    output int                   open_results
);

    typedef enum logic [2:0] {
        AWAIT_HDR0 = 3'd0,
        AWAIT_HDR1 = 3'd1,
        EXT_LEN    = 3'd2,
        MASK_KEY   = 3'd3,
        PAYLOAD    = 3'd4
    } parse_phase_t;

    // parser state as the block should hold it
    parse_phase_t         phase;
    logic [2:0]           ext_left;
    logic [1:0]           key_cnt;
    logic                 cur_fin;
    logic [3:0]           cur_opcode;
    logic                 cur_masked;
    logic [63:0]          bytes_left;
    logic [31:0]          key_word;
    logic [1:0]           key_pos;
    logic [MAX_LEN_W-1:0] len_limit;

    // beats still owed by the block, oldest first
    result_t deframed_q[$];

    // result beat tagged with the current frame header
    function automatic result_t form_result(input kind_t k, input logic [7:0] b,
                                            input logic last);
        result_t r;
        r.kind          = k;
        r.payload_byte  = b;
        r.fin_flag      = cur_fin;
        r.frame_opcode  = cur_opcode;
        r.was_masked    = cur_masked;
        r.last_of_frame = last;
        return r;
    endfunction

    // key done or not needed: empty frame or start of payload
    function automatic bit open_payload(output result_t r);
        r       = '0;
        key_pos = 2'd0;
        if (bytes_left == 64'd0)
        begin
            phase = AWAIT_HDR0;
            r     = form_result(KIND_EMPTY, 8'h00, 1'b1);
            return 1'b1;
        end
        phase = PAYLOAD;
        return 1'b0;
    endfunction

    // full length known: limit check, then key or payload
    function automatic bit check_length(output result_t r);
        r = '0;
        if (bytes_left > {1'b0, len_limit})
        begin
            phase      = AWAIT_HDR0;
            bytes_left = 64'd0;
            r          = form_result(KIND_LEN_ERR, 8'h00, 1'b1);
            return 1'b1;
        end
        if (cur_masked)
        begin
            key_cnt  = 2'd0;
            key_word = 32'd0;
            phase    = MASK_KEY;
            return 1'b0;
        end
        return open_payload(r);
    endfunction

    // one stream byte through the parser; returns 1 when a beat is due
    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        logic [7:0] key_b;
        r = '0;
        case (phase)
            AWAIT_HDR1:
            begin
                cur_masked = b[7];
                if (b[6:0] == LEN_EXT16)
                begin
                    ext_left   = 3'd1;
                    bytes_left = 64'd0;
                    phase      = EXT_LEN;
                    return 1'b0;
                end
                if (b[6:0] == LEN_EXT64)
                begin
                    ext_left   = 3'd7;
                    bytes_left = 64'd0;
                    phase      = EXT_LEN;
                    return 1'b0;
                end
                bytes_left = {57'd0, b[6:0]};
                return check_length(r);
            end
            EXT_LEN:
            begin
                bytes_left = {bytes_left[55:0], b};
                if (ext_left == 3'd0)
                    return check_length(r);
                ext_left = ext_left - 3'd1;
                return 1'b0;
            end
            MASK_KEY:
            begin
                key_word[{key_cnt, 3'b000} +: 8] = b;
                if (key_cnt == 2'd3)
                begin
                    key_cnt = 2'd0;
                    return open_payload(r);
                end
                key_cnt = key_cnt + 2'd1;
                return 1'b0;
            end
            PAYLOAD:
            begin
                key_b      = cur_masked ? key_word[{key_pos, 3'b000} +: 8] : 8'h00;
                key_pos    = key_pos + 2'd1;
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 64'd0)
                    phase = AWAIT_HDR0;
                r = form_result(KIND_DATA, b ^ key_b, bytes_left == 64'd0);
                return 1'b1;
            end
            default:
            begin
                cur_fin    = b[7];
                cur_opcode = b[3:0];
                cur_masked = 1'b0;
                if ((b & RSV_MASK) != 8'h00)
                begin
                    phase = AWAIT_HDR0;
                    r     = form_result(KIND_RSV_ERR, 8'h00, 1'b1);
                    return 1'b1;
                end
                phase = AWAIT_HDR1;
                return 1'b0;
            end
        endcase
    endfunction

    // count a bad beat, show the first few
    task automatic report_beat(input string why, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected kind=%0d byte=%02h fin=%0b op=%0h masked=%0b last=%0b",
                     $time, why, want.kind, want.payload_byte, want.fin_flag,
                     want.frame_opcode, want.was_masked, want.last_of_frame,
                     "  got kind=%0d byte=%02h fin=%0b op=%0h masked=%0b last=%0b",
                     got.kind, got.payload_byte, got.fin_flag, got.frame_opcode,
                     got.was_masked, got.last_of_frame);
    endtask

    // track inputs, compare output beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            phase      = AWAIT_HDR0;
            ext_left   = 3'd0;
            key_cnt    = 2'd0;
            cur_fin    = 1'b0;
            cur_opcode = 4'd0;
            cur_masked = 1'b0;
            bytes_left = 64'd0;
            key_word   = 32'd0;
            key_pos    = 2'd0;
            len_limit  = '1;
            deframed_q.delete();
            open_results <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                len_limit = cfg_wr_data;

            // new stream byte
            if (in_ch.valid && in_ch.ready)
            begin
                if (deframe_byte(in_ch.stream_byte, want))
                    deframed_q.push_back(want);
            end

            // result beat taken
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind          = kind_t'(out_ch.kind);
                got.payload_byte  = out_ch.payload_byte;
                got.fin_flag      = out_ch.fin_flag;
                got.frame_opcode  = out_ch.frame_opcode;
                got.was_masked    = out_ch.was_masked;
                got.last_of_frame = out_ch.last_of_frame;
                if (deframed_q.size() == 0)
                    report_beat("beat with none outstanding", '0, got);
                else
                begin
                    want = deframed_q.pop_front();
                    if (got.kind !== want.kind ||
                        got.payload_byte !== want.payload_byte ||
                        got.fin_flag !== want.fin_flag ||
                        got.frame_opcode !== want.frame_opcode ||
                        got.was_masked !== want.was_masked ||
                        got.last_of_frame !== want.last_of_frame)
                        report_beat("beat differs", want, got);
                end
            end
            open_results <= deframed_q.size();
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for the websocket frame deframer
// Feeds hand-picked frames, then random frames, truncated frames and stray
// bytes under several length limits, with random gaps on both channels;
// the checker beside the block judges every result beat.
// ----------------------------------------------------------------------------
module tb;
    import wsd_pkg::*;

    typedef enum int {
        FORM_7,
        FORM_16,
        FORM_64
    } len_form_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [MAX_LEN_W-1:0] cfg_wr_data;
    int                   mismatch_count;
    int                   open_results;

    // stimulus bookkeeping
    logic [MAX_LEN_W-1:0] cur_limit;
    int                   sent_count;
    int                   hold_requests;
    int                   holds_done;
    bit                   send_steady;
    bit                   recv_steady;

    wsd_in_if  in_ch();
    wsd_out_if out_ch();

    websocket_frame_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    deframe_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatch_count (mismatch_count),
        .open_results   (open_results)
    );

    always #1 clk = ~clk;

    // gap length: mostly short, now and then long
    function automatic int idle_cycles();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // one stream beat, with an optional gap before it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < 3)
            send_steady = !send_steady;
        if (!send_steady && $urandom_range(0, 99) < 35)
            gap = idle_cycles();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.stream_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent_count++;
    endtask

    // build a frame; key and payload only when the length passes the limit
    task automatic send_frame(input logic fin, input logic [2:0] rsv,
                              input logic [3:0] opcode, input logic masked,
                              input len_form_t form, input logic [63:0] length,
                              input bit truncate);
        logic [7:0] frame_q[$];
        int         keep;
        frame_q.push_back({fin, rsv, opcode});
        case (form)
            FORM_16:
            begin
                frame_q.push_back({masked, LEN_EXT16});
                frame_q.push_back(length[15:8]);
                frame_q.push_back(length[7:0]);
            end
            FORM_64:
            begin
                frame_q.push_back({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    frame_q.push_back(length[8*i +: 8]);
            end
            default:
                frame_q.push_back({masked, length[6:0]});
        endcase
        if (length <= {1'b0, cur_limit})
        begin
            if (masked)
                repeat (4) frame_q.push_back(8'($urandom));
            for (longint i = 0; i < length; i++)
                frame_q.push_back(8'($urandom));
        end
        keep = frame_q.size();
        if (truncate && keep > 1)
            keep = $urandom_range(1, keep - 1);
        for (int i = 0; i < keep; i++)
            send_byte(frame_q[i]);
    endtask

    // random frame, or stray bytes and broken frames when noisy
    task automatic random_item(input bit noisy);
        int          pick;
        int          shape;
        bit          truncate;
        logic [2:0]  rsv;
        logic [63:0] length;
        len_form_t   form;
        pick = $urandom_range(0, 99);
        if (noisy && pick < 8)
        begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            return;
        end
        rsv      = (noisy && pick < 14) ? 3'($urandom_range(1, 7)) : 3'd0;
        truncate = noisy && pick >= 14 && pick < 20;

        // mostly short payloads; long lengths only where they fail the limit
        shape = $urandom_range(0, 99);
        if (shape < 15)
            length = 64'd0;
        else if (shape < 70)
            length = 64'($urandom_range(1, 12));
        else if (shape < 80)
            length = 64'($urandom_range(13, 60));
        else
        begin
            if ($urandom_range(0, 1) == 1)
                length = {$urandom, $urandom};
            else
                length = 64'($urandom_range(126, 65535));
            if (length <= {1'b0, cur_limit})
                length = 64'($urandom_range(1, 8));
        end

        // length encoding, the longer forms also for small values
        if (length > 64'hFFFF)
            form = FORM_64;
        else if (length > 64'd125)
            form = ($urandom_range(0, 1) == 1) ? FORM_16 : FORM_64;
        else
        begin
            shape = $urandom_range(0, 99);
            form  = (shape < 70) ? FORM_7 : (shape < 85) ? FORM_16 : FORM_64;
        end
        send_frame(1'($urandom_range(0, 1)), rsv, 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), form, length, truncate);
    endtask

    task automatic run_random(input int count, input bit noisy);
        int stop_at;
        stop_at = sent_count + count;
        while (sent_count < stop_at)
            random_item(noisy);
    endtask

    // bytes with reserved bits set bring the parser back to a header
    task automatic resync();
        repeat (int'(cur_limit) + 16) send_byte(8'h70 | 8'($urandom));
    endtask

    // stop sending and let every owed beat drain
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (open_results != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_limit(input logic [MAX_LEN_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_limit   = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stalls, long hold-off on request
    initial
    begin : result_sink
        int stall;
        stall        = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < 2)
                recv_steady = !recv_steady;
            if (holds_done < hold_requests)
            begin
                holds_done++;
                stall = 250;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else if (recv_steady || $urandom_range(0, 99) < 65)
                out_ch.ready <= 1'b1;
            else
            begin
                out_ch.ready <= 1'b0;
                stall = idle_cycles() - 1;
            end
        end
    end

    // stream side and verdict
    initial
    begin : stimulus
        in_ch.valid       = 1'b0;
        in_ch.stream_byte = 8'h00;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        cur_limit         = '1;
        rst_n             = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // widest limit, hand-picked frames
        write_limit('1);
        send_byte(8'hF5);   // all reserved bits set
        send_byte(8'h2A);   // one reserved bit
        send_frame(1'b1, 3'd0, 4'hF, 1'b0, FORM_7, 64'd0, 1'b0);   // empty frame
        send_frame(1'b0, 3'd0, 4'h9, 1'b1, FORM_7, 64'd0, 1'b0);   // empty after key
        send_frame(1'b1, 3'd0, 4'h1, 1'b1, FORM_7, 64'd5, 1'b0);   // key index wraps
        // 64-bit length with top bit set
        send_frame(1'b1, 3'd0, 4'h2, 1'b1, FORM_64, 64'h8000_0000_0000_0000, 1'b0);

        // clean random frames; receiver holds off while bytes keep coming
        run_random(30, 1'b0);
        hold_requests = 1;
        run_random(100, 1'b0);
        wait_idle();

        // zero limit: any non-empty frame is a length error
        write_limit('0);
        run_random(70, 1'b1);
        resync();
        wait_idle();

        // tiny limit with noise
        write_limit(MAX_LEN_W'($urandom_range(1, 24)));
        run_random(100, 1'b1);
        resync();
        wait_idle();

        // middle limit, clean frames
        write_limit(MAX_LEN_W'($urandom_range(100, 400)));
        run_random(60, 1'b0);
        wait_idle();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && open_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hang guard
    initial
    begin : watchdog
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: websocket_frame_deframer.f
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_if.sv
hw/rtl/wsd_parser.sv
hw/rtl/websocket_frame_deframer.sv
sim/deframe_checker.sv
sim/tb.sv
